[rtl/core/size_class_slab_allocator_assert.svh]
// Assertion macros used by the checker file of the slab allocator.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCSA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scsa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCSA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scsa assertion failed");

`endif

[rtl/core/scsa_pkg.sv]
// Shared constants of the size class slab allocator.
`timescale 1ns / 1ps
package scsa_pkg;

  // Fixed field widths.
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned REQ_W    = 24;
  localparam int unsigned ADDR_W   = 23;
  localparam int unsigned STRIDE_W = 14;
  localparam int unsigned POS_W    = 26;
  localparam int unsigned LIVE_W   = 11;
  localparam int unsigned CHG_W    = 25;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned REG_CLASSES = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_A  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_A = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END     = 4'd8;

  // Request functions.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE     = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED     = 3'd2;
  localparam logic [2:0] ST_MISALIGNED    = 3'd3;
  localparam logic [2:0] ST_DOUBLE_FREE   = 3'd4;
  localparam logic [2:0] ST_FOREIGN       = 3'd5;
  localparam logic [2:0] ST_CLASS_INVALID = 3'd6;

endpackage

[rtl/core/scsa_if.sv]
// Request and response channel interfaces of the slab allocator.
`timescale 1ns / 1ps
interface scsa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [23:0] request_bytes;
  logic [22:0] block_address;

  modport source (output valid, func, request_bytes, block_address, input ready);
  modport sink   (input valid, func, request_bytes, block_address, output ready);
endinterface

interface scsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [22:0] granted_address;
  logic [1:0]  slab_class;
  logic [8:0]  class_free_slots;
  logic [10:0] held_blocks;
  logic [10:0] held_blocks_max;
  logic [22:0] stride_bytes;
  logic [22:0] stride_bytes_max;

  modport source (output valid, status, granted_address, slab_class, class_free_slots,
                  held_blocks, held_blocks_max, stride_bytes, stride_bytes_max,
                  input ready);
  modport sink   (input valid, status, granted_address, slab_class, class_free_slots,
                  held_blocks, held_blocks_max, stride_bytes, stride_bytes_max,
                  output ready);
endinterface

[rtl/core/size_class_slab_allocator.sv]
// Size class slab allocator: layout walk, class search, slot divider and free lists.
//
//   channel | direction | handshake      | carries
//   --------+-----------+----------------+-------------------------------------------
//   req     | in        | valid / ready  | func, request_bytes, block_address
//   rsp     | out       | valid / ready  | status, address, class, slot and totals
//   cfg     | in        | cfg_we_i       | cfg_index_i, cfg_data_i
//
// An allocate scans the classes in order, reads the link when the list head is a reused slot,
// then forms the stride product and the address, loads the output word and returns to idle.
// A good free runs the 9-step shift-subtract divider that turns the offset into a slot number,
// then the link read and write; rejected words leave the sequence early.
// Reset and every register write run a layout walk over the classes in order, input blocked.
// A stalled output word holds the next result in its last step and blocks the input.
`timescale 1ns / 1ps
module size_class_slab_allocator
  import scsa_pkg::*;
#(
  parameter int unsigned CLASSES         = 4,
  parameter int unsigned SLOTS_PER_CLASS = 256,
  parameter int unsigned BLOCK_ALIGN     = 8,
  parameter int unsigned MAX_SLOT_BYTES  = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  scsa_req_if.sink             req,
  scsa_rsp_if.source           rsp,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  localparam int unsigned LIVE  = (CLASSES < REG_CLASSES) ? CLASSES : REG_CLASSES;
  localparam int unsigned CIW   = (LIVE > 1) ? $clog2(LIVE) : 1;
  localparam int unsigned SW    = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam int unsigned LW    = SW + 1;
  localparam int unsigned DEPTH = LIVE * SLOTS_PER_CLASS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LW-1:0] LINK_FRESH = {1'b1, {SW{1'b0}}};

  // Sequencer states.
  localparam logic [3:0] S_BUILD = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_FCHK  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RDW   = 4'd6;
  localparam logic [3:0] S_AMUL  = 4'd7;
  localparam logic [3:0] S_AADR  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Stride of a class: size rounded up to the alignment, at least 4.
  function automatic logic [STRIDE_W-1:0] stride_of(input logic [SIZE_W-1:0] size);
    logic [STRIDE_W-1:0] s;
    s = ({1'b0, size} + STRIDE_W'(BLOCK_ALIGN - 1)) & ~STRIDE_W'(BLOCK_ALIGN - 1);
    if (s < STRIDE_W'(4)) begin
      s = STRIDE_W'(4);
    end
    return s;
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0]  size_q  [REG_CLASSES];
  logic [COUNT_W-1:0] count_q [REG_CLASSES];

  // Per-class state.
  logic [POS_W-1:0]   base_q  [LIVE];
  logic [POS_W-1:0]   end_q   [LIVE];
  logic [LW-1:0]      head_q  [LIVE];
  logic [COUNT_W-1:0] fill_q  [LIVE];
  logic [COUNT_W-1:0] free_q  [LIVE];

  // Totals.
  logic [LIVE_W-1:0] live_q, live_peak_q;
  logic [CHG_W-1:0]  chg_q, chg_peak_q;

  // Sequencer and datapath registers.
  logic [3:0]         state_q;
  logic [CIW-1:0]     cls_q;
  logic               func_q;
  logic [REQ_W-1:0]   bytes_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [POS_W-1:0]   cursor_q;
  logic [ADDR_W-1:0]  rem_q;
  logic [COUNT_W-1:0] quo_q;
  logic [3:0]         bit_q;
  logic [SW-1:0]      slot_q;
  logic [POS_W-1:0]   prod_q;

  // Staged result.
  logic [2:0]         res_status_q;
  logic [ADDR_W-1:0]  res_addr_q;
  logic [CIW-1:0]     res_cls_q;
  logic [COUNT_W-1:0] res_free_q;

  // Output register.
  logic               out_valid_q;
  logic [2:0]         out_status_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [1:0]         out_cls_q;
  logic [COUNT_W-1:0] out_free_q;
  logic [LIVE_W-1:0]  out_live_q, out_live_peak_q;
  logic [ADDR_W-1:0]  out_chg_q, out_chg_peak_q;

  // Link memory: in-use flag and next link for each slot.
  logic [LW:0]        mem_q [DEPTH];
  logic [LW:0]        rd_q;
  logic [AW-1:0]      mem_addr;
  logic               mem_re, mem_we;
  logic [LW:0]        mem_wdata;

  // Class table check.
  logic [LIVE-1:0] act_raw, act_c;
  logic            table_ok_c;

  always_comb begin
    logic run;
    run = 1'b1;
    table_ok_c = 1'b1;
    for (int i = 0; i < LIVE; i++) begin
      run = run & (count_q[i] != '0);
      act_raw[i] = run;
      if (act_raw[i]) begin
        if (size_q[i] == '0 || {4'b0, size_q[i]} > 17'(MAX_SLOT_BYTES) ||
            {2'b0, count_q[i]} > 11'(SLOTS_PER_CLASS)) begin
          table_ok_c = 1'b0;
        end
        if (i != 0) begin
          if (size_q[i] <= size_q[i-1]) begin
            table_ok_c = 1'b0;
          end
        end
      end
    end
    if (!act_raw[0]) begin
      table_ok_c = 1'b0;
    end
    act_c = table_ok_c ? act_raw : '0;
  end

  // Values of the class under the sequencer.
  logic [STRIDE_W-1:0] cur_stride;
  logic [COUNT_W-1:0]  cur_cnt;
  logic [POS_W-1:0]    bm_pos, blk_pos, trial;
  logic                last_cls, scan_hit;

  assign cur_stride = stride_of(size_q[cls_q]);
  assign cur_cnt    = act_c[cls_q] ? count_q[cls_q] : '0;
  assign bm_pos     = (cursor_q + POS_W'(3)) & ~POS_W'(3);
  assign blk_pos    = (bm_pos + POS_W'(((cur_cnt + COUNT_W'(31)) >> 5)) * POS_W'(4)
                       + POS_W'(BLOCK_ALIGN - 1)) & ~POS_W'(BLOCK_ALIGN - 1);
  assign trial      = POS_W'(cur_stride) << bit_q;
  assign last_cls   = (cls_q == CIW'(LIVE - 1));
  assign scan_hit   = act_c[cls_q] &&
                      ((func_q == FUNC_ALLOC) ? ({11'b0, size_q[cls_q]} >= bytes_q)
                       : (POS_W'(addr_q) >= base_q[cls_q] && POS_W'(addr_q) < end_q[cls_q]));

  // Memory port control.
  assign mem_addr  = AW'(cls_q) * AW'(SLOTS_PER_CLASS) + AW'(slot_q);
  assign mem_re    = (state_q == S_RD);
  assign mem_we    = (state_q == S_AMUL) ||
                     (state_q == S_RDW && func_q == FUNC_FREE && rd_q[LW]);
  assign mem_wdata = (state_q == S_AMUL) ? {1'b1, {LW{1'b0}}} : {1'b0, head_q[cls_q]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SIZE_W'(16);
      size_q[1] <= SIZE_W'(64);
      size_q[2] <= SIZE_W'(256);
      size_q[3] <= SIZE_W'(1024);
      for (int i = 0; i < REG_CLASSES; i++) begin
        count_q[i] <= COUNT_W'(256);
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i < REG_COUNT_A) begin
        size_q[cfg_index_i[1:0]] <= cfg_data_i;
      end else if (cfg_index_i < REG_END) begin
        count_q[cfg_index_i[1:0]] <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  // Sequencer, layout walk and allocator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BUILD;
      cls_q       <= '0;
      cursor_q    <= '0;
      live_q      <= '0;
      live_peak_q <= '0;
      chg_q       <= '0;
      chg_peak_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LIVE; i++) begin
        head_q[i] <= LINK_FRESH;
        fill_q[i] <= '0;
        free_q[i] <= '0;
      end
    end else begin
      if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_BUILD: begin
          base_q[cls_q] <= act_c[cls_q] ? blk_pos : '0;
          end_q[cls_q]  <= act_c[cls_q] ?
                           blk_pos + POS_W'(cur_stride) * POS_W'(cur_cnt) : '0;
          if (act_c[cls_q]) begin
            cursor_q <= blk_pos + POS_W'(cur_stride) * POS_W'(cur_cnt);
          end
          head_q[cls_q] <= LINK_FRESH;
          fill_q[cls_q] <= '0;
          free_q[cls_q] <= cur_cnt;
          if (last_cls) begin
            state_q <= S_IDLE;
          end else begin
            cls_q <= cls_q + CIW'(1);
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            func_q  <= req.func;
            bytes_q <= (req.request_bytes == '0) ? REQ_W'(1) : req.request_bytes;
            addr_q  <= req.block_address;
            cls_q   <= '0;
            res_addr_q <= '0;
            res_cls_q  <= '0;
            res_free_q <= '0;
            if (!table_ok_c) begin
              res_status_q <= ST_CLASS_INVALID;
              state_q      <= S_DONE;
            end else if (req.func == FUNC_FREE && req.block_address == '0) begin
              res_status_q <= ST_OK;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            res_cls_q <= cls_q;
            if (func_q == FUNC_ALLOC) begin
              if (free_q[cls_q] == '0) begin
                res_status_q <= ST_EXHAUSTED;
                state_q      <= S_DONE;
              end else if (head_q[cls_q][SW]) begin
                slot_q        <= SW'(fill_q[cls_q]);
                fill_q[cls_q] <= fill_q[cls_q] + COUNT_W'(1);
                state_q       <= S_AMUL;
              end else begin
                slot_q  <= head_q[cls_q][SW-1:0];
                state_q <= S_RD;
              end
            end else begin
              rem_q   <= ADDR_W'(POS_W'(addr_q) - base_q[cls_q]);
              quo_q   <= '0;
              bit_q   <= 4'(COUNT_W - 1);
              state_q <= S_DIV;
            end
          end else if (last_cls) begin
            res_status_q <= (func_q == FUNC_ALLOC) ? ST_TOO_LARGE : ST_FOREIGN;
            state_q      <= S_DONE;
          end else begin
            cls_q <= cls_q + CIW'(1);
          end
        end
        // One quotient bit per cycle.
        S_DIV: begin
          if (POS_W'(rem_q) >= trial) begin
            rem_q        <= ADDR_W'(POS_W'(rem_q) - trial);
            quo_q[bit_q] <= 1'b1;
          end
          if (bit_q == '0) begin
            state_q <= S_FCHK;
          end else begin
            bit_q <= bit_q - 4'd1;
          end
        end
        S_FCHK: begin
          res_free_q <= free_q[cls_q];
          if (rem_q != '0) begin
            res_status_q <= ST_MISALIGNED;
            state_q      <= S_DONE;
          end else if ({2'b0, quo_q} >= 11'(SLOTS_PER_CLASS) || quo_q >= fill_q[cls_q]) begin
            res_status_q <= ST_DOUBLE_FREE;
            state_q      <= S_DONE;
          end else begin
            slot_q  <= SW'(quo_q);
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_RDW;
        end
        S_RDW: begin
          if (func_q == FUNC_ALLOC) begin
            head_q[cls_q] <= rd_q[LW-1:0];
            state_q       <= S_AMUL;
          end else if (!rd_q[LW]) begin
            res_status_q <= ST_DOUBLE_FREE;
            state_q      <= S_DONE;
          end else begin
            head_q[cls_q] <= {1'b0, slot_q};
            free_q[cls_q] <= free_q[cls_q] + COUNT_W'(1);
            res_free_q    <= free_q[cls_q] + COUNT_W'(1);
            live_q        <= live_q - LIVE_W'(1);
            chg_q         <= chg_q - CHG_W'(cur_stride);
            res_status_q  <= ST_OK;
            state_q       <= S_DONE;
          end
        end
        S_AMUL: begin
          prod_q        <= POS_W'(cur_stride) * POS_W'(slot_q);
          free_q[cls_q] <= free_q[cls_q] - COUNT_W'(1);
          state_q       <= S_AADR;
        end
        S_AADR: begin
          res_addr_q   <= ADDR_W'(base_q[cls_q] + prod_q);
          res_free_q   <= free_q[cls_q];
          res_status_q <= ST_OK;
          live_q       <= live_q + LIVE_W'(1);
          chg_q        <= chg_q + CHG_W'(cur_stride);
          if (live_q + LIVE_W'(1) > live_peak_q) begin
            live_peak_q <= live_q + LIVE_W'(1);
          end
          if (chg_q + CHG_W'(cur_stride) > chg_peak_q) begin
            chg_peak_q <= chg_q + CHG_W'(cur_stride);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || rsp.ready) begin
            out_valid_q     <= 1'b1;
            out_status_q    <= res_status_q;
            out_addr_q      <= res_addr_q;
            out_cls_q       <= 2'(res_cls_q);
            out_free_q      <= res_free_q;
            out_live_q      <= live_q;
            out_live_peak_q <= live_peak_q;
            out_chg_q       <= ADDR_W'(chg_q);
            out_chg_peak_q  <= ADDR_W'(chg_peak_q);
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_BUILD;
          cls_q   <= '0;
        end
      endcase
      // A register write rebuilds the whole state.
      if (cfg_we_i && cfg_index_i < REG_END) begin
        state_q     <= S_BUILD;
        cls_q       <= '0;
        cursor_q    <= '0;
        live_q      <= '0;
        live_peak_q <= '0;
        chg_q       <= '0;
        chg_peak_q  <= '0;
      end
    end
  end

  // Port drive.
  assign req.ready            = (state_q == S_IDLE);
  assign rsp.valid            = out_valid_q;
  assign rsp.status           = out_status_q;
  assign rsp.granted_address  = out_addr_q;
  assign rsp.slab_class       = out_cls_q;
  assign rsp.class_free_slots = out_free_q;
  assign rsp.held_blocks      = out_live_q;
  assign rsp.held_blocks_max  = out_live_peak_q;
  assign rsp.stride_bytes     = out_chg_q;
  assign rsp.stride_bytes_max = out_chg_peak_q;

endmodule

[rtl/core/scsa_checker.sv]
// Port-level checker of the slab allocator and its bind.
`timescale 1ns / 1ps
`include "size_class_slab_allocator_assert.svh"
module scsa_checker
  import scsa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [22:0] granted_address,
  input logic [1:0]  slab_class
);

  logic rsp_invalid, rsp_clean, rsp_stall;

  assign rsp_invalid = out_valid && status == ST_CLASS_INVALID;
  assign rsp_clean   = slab_class == 2'd0 && granted_address == 23'd0;
  assign rsp_stall   = out_valid && !out_ready;

  // One word at a time: ready drops right after an accept.
  `SCSA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)

  // An invalid class table answers with no class and no address.
  `SCSA_ASSERT_IMP(a_invalid_clean, clk_i, rst_ni, rsp_invalid, rsp_clean)

  // Only a granted allocate carries an address.
  `SCSA_ASSERT_IMP(a_fail_no_addr, clk_i, rst_ni, out_valid && status != ST_OK, granted_address == 23'd0)

  // A stalled response word holds.
  `SCSA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, out_valid && $stable(granted_address))

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .out_valid       (rsp.valid),
  .out_ready       (rsp.ready),
  .status          (rsp.status),
  .granted_address (rsp.granted_address),
  .slab_class      (rsp.slab_class)
);
